// File: rtl/core/stsi_pkg.sv
// Shared types and constants for the sorted table block.
// Used by stsi_ctrl, stsi_dp and the top level; no dependencies.
package stsi_pkg;

  localparam int ValueWidth = 32;
  localparam int ReqWidth   = 2;
  localparam int StatWidth  = 2;
  localparam int IdxWidth   = 5;
  localparam int CountWidth = 6;
  localparam int OutWidth   = 16;

  localparam logic [ReqWidth-1:0] REQ_INSERT = 2'd0;
  localparam logic [ReqWidth-1:0] REQ_REMOVE = 2'd1;
  localparam logic [ReqWidth-1:0] REQ_SEARCH = 2'd2;

  localparam logic [StatWidth-1:0] ST_OK      = 2'd0;
  localparam logic [StatWidth-1:0] ST_FULL    = 2'd1;
  localparam logic [StatWidth-1:0] ST_MISSING = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE,
    S_BS_RD,
    S_BS_CMP,
    S_CHK_CMP,
    S_INS_SH,
    S_RM_SCAN,
    S_RM_SH,
    S_DONE
  } state_t;

  typedef struct packed {
    logic                 load;
    logic                 bs_issue;
    logic                 bs_step;
    logic                 chk_issue;
    logic                 scan_step;
    logic                 sh_init_dn;
    logic                 sh_init_up;
    logic                 sh_up_step;
    logic                 sh_dn_step;
    logic                 write_val;
    logic                 dec_cnt;
    logic                 set_res;
    logic [StatWidth-1:0] res_status;
    logic                 res_found;
    logic                 push;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic lo_lt_hi;
    logic lo_lt_cnt;
    logic eq;
    logic match;
    logic ptr_lt_cnt;
    logic ptr_gt_lo;
    logic pend;
    logic out_free;
  } stat_t;

endpackage

// File: rtl/core/stsi_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module stsi_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     wen,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     ren,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wen) begin
      mem[waddr] <= wdata;
    end
    if (ren) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/core/stsi_dp.sv
// Datapath: entry RAM, search bounds, shift pointers, count and result register.
// Depends on stsi_pkg and stsi_ram; driven by commands from stsi_ctrl.
module stsi_dp #(
  parameter int CAPACITY = 32
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   cfg_we,
  input  logic                                   cfg_wdata,
  input  logic signed [stsi_pkg::ValueWidth-1:0] in_value,
  input  stsi_pkg::cmd_t                         cmd,
  output stsi_pkg::stat_t                        stat,
  output logic                                   m_tvalid,
  input  logic                                   m_tready,
  output logic [stsi_pkg::OutWidth-1:0]          m_tdata
);

  localparam int AW  = $clog2(CAPACITY);
  localparam int CW  = $clog2(CAPACITY + 1);
  localparam int VW  = stsi_pkg::ValueWidth;
  localparam int IW  = stsi_pkg::IdxWidth;
  localparam int NW  = stsi_pkg::CountWidth;
  localparam int SW  = stsi_pkg::StatWidth;

  logic                 descending;
  logic signed [VW-1:0] val;
  logic [CW-1:0]        cnt;
  logic [CW-1:0]        lo;
  logic [CW-1:0]        hi;
  logic [CW-1:0]        ptr;
  logic [CW-1:0]        wa;
  logic                 pend;
  logic [SW-1:0]        res_status;
  logic                 res_found;

  logic [SW-1:0]        out_status;
  logic [IW-1:0]        out_idx;
  logic [NW-1:0]        out_count;

  logic [CW:0]          mid_sum;
  logic [CW-1:0]        mid;
  logic signed [VW-1:0] rdata;
  logic                 precedes;

  logic                 ram_wen;
  logic [AW-1:0]        ram_waddr;
  logic [VW-1:0]        ram_wdata;
  logic                 ram_ren;
  logic [AW-1:0]        ram_raddr;

  logic [CW+IW-1:0]     idx_ext;
  logic [CW+NW-1:0]     cnt_ext;

  stsi_ram #(
    .WIDTH(VW),
    .DEPTH(CAPACITY)
  ) u_ram (
    .clk  (clk),
    .wen  (ram_wen),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .ren  (ram_ren),
    .raddr(ram_raddr),
    .rdata(rdata)
  );

  assign mid_sum  = {1'b0, lo} + {1'b0, hi};
  assign mid      = mid_sum[CW:1];
  assign precedes = descending ? (rdata > val) : (rdata < val);

  always_comb begin
    stat.full       = (cnt >= CW'(CAPACITY));
    stat.lo_lt_hi   = (lo < hi);
    stat.lo_lt_cnt  = (lo < cnt);
    stat.eq         = (rdata == val);
    stat.match      = pend && (rdata == val);
    stat.ptr_lt_cnt = (ptr < cnt);
    stat.ptr_gt_lo  = (ptr > lo);
    stat.pend       = pend;
    stat.out_free   = !m_tvalid || m_tready;
  end

  // RAM ports
  always_comb begin
    ram_ren   = 1'b0;
    ram_raddr = '0;
    ram_wen   = 1'b0;
    ram_waddr = wa[AW-1:0];
    ram_wdata = rdata;
    if (cmd.bs_issue) begin
      ram_ren   = 1'b1;
      ram_raddr = mid[AW-1:0];
    end else if (cmd.chk_issue) begin
      ram_ren   = 1'b1;
      ram_raddr = lo[AW-1:0];
    end else if ((cmd.scan_step || cmd.sh_dn_step) && stat.ptr_lt_cnt) begin
      ram_ren   = 1'b1;
      ram_raddr = ptr[AW-1:0];
    end else if (cmd.sh_up_step && stat.ptr_gt_lo) begin
      ram_ren   = 1'b1;
      ram_raddr = AW'(ptr - CW'(1));
    end
    if ((cmd.sh_up_step || cmd.sh_dn_step) && pend) begin
      ram_wen = 1'b1;
    end else if (cmd.write_val) begin
      ram_wen   = 1'b1;
      ram_waddr = lo[AW-1:0];
      ram_wdata = val;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      descending <= 1'b0;
      cnt        <= '0;
      pend       <= 1'b0;
      m_tvalid   <= 1'b0;
    end else begin
      if (cfg_we) begin
        descending <= cfg_wdata;
      end
      if (cmd.write_val) begin
        cnt <= cnt + CW'(1);
      end else if (cmd.dec_cnt) begin
        cnt <= cnt - CW'(1);
      end
      if (cmd.load || cmd.sh_init_dn || cmd.sh_init_up) begin
        pend <= 1'b0;
      end else if (cmd.scan_step || cmd.sh_dn_step) begin
        pend <= stat.ptr_lt_cnt;
      end else if (cmd.sh_up_step) begin
        pend <= stat.ptr_gt_lo;
      end
      if (cmd.push) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      val <= in_value;
      lo  <= '0;
      hi  <= cnt;
      ptr <= '0;
    end
    if (cmd.bs_issue) begin
      ptr <= mid;
    end
    if (cmd.bs_step) begin
      if (precedes) begin
        lo <= ptr + CW'(1);
      end else begin
        hi <= ptr;
      end
    end
    if (cmd.scan_step && stat.ptr_lt_cnt) begin
      wa  <= ptr;
      ptr <= ptr + CW'(1);
    end
    if (cmd.sh_init_dn) begin
      lo  <= wa;
      ptr <= wa + CW'(1);
    end
    if (cmd.sh_init_up) begin
      ptr <= cnt;
    end
    if (cmd.sh_dn_step && stat.ptr_lt_cnt) begin
      wa  <= ptr - CW'(1);
      ptr <= ptr + CW'(1);
    end
    if (cmd.sh_up_step) begin
      wa <= ptr;
      if (stat.ptr_gt_lo) begin
        ptr <= ptr - CW'(1);
      end
    end
    if (cmd.set_res) begin
      res_status <= cmd.res_status;
      res_found  <= cmd.res_found;
    end
    if (cmd.push) begin
      out_status <= res_status;
      out_idx    <= res_found ? idx_ext[IW-1:0] : '0;
      out_count  <= cnt_ext[NW-1:0];
    end
  end

  assign idx_ext = {{IW{1'b0}}, lo};
  assign cnt_ext = {{NW{1'b0}}, cnt};

  assign m_tdata = {{(stsi_pkg::OutWidth - SW - IW - NW){1'b0}}, out_count, out_idx, out_status};

endmodule

// File: rtl/core/stsi_ctrl.sv
// Request sequencer: binary search, linear scan and one-per-cycle shift steps.
// Depends on stsi_pkg; issues commands to stsi_dp and reads its status.
module stsi_ctrl (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [stsi_pkg::ReqWidth-1:0]     s_tuser,
  output stsi_pkg::cmd_t                    cmd,
  input  stsi_pkg::stat_t                   stat
);

  stsi_pkg::state_t                  state;
  stsi_pkg::state_t                  state_next;
  logic [stsi_pkg::ReqWidth-1:0]     req;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= stsi_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (state == stsi_pkg::S_IDLE && s_tvalid) begin
      req <= s_tuser;
    end
  end

  always_comb begin
    state_next     = state;
    cmd            = '0;
    cmd.res_status = stsi_pkg::ST_OK;
    s_tready       = 1'b0;
    unique case (state)
      stsi_pkg::S_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.load = 1'b1;
          case (s_tuser)
            stsi_pkg::REQ_INSERT: begin
              if (stat.full) begin
                cmd.set_res    = 1'b1;
                cmd.res_status = stsi_pkg::ST_FULL;
                state_next     = stsi_pkg::S_DONE;
              end else begin
                state_next = stsi_pkg::S_BS_RD;
              end
            end
            stsi_pkg::REQ_REMOVE: state_next = stsi_pkg::S_RM_SCAN;
            stsi_pkg::REQ_SEARCH: state_next = stsi_pkg::S_BS_RD;
            default: begin
              cmd.set_res = 1'b1;
              state_next  = stsi_pkg::S_DONE;
            end
          endcase
        end
      end
      stsi_pkg::S_BS_RD: begin
        if (stat.lo_lt_hi) begin
          cmd.bs_issue = 1'b1;
          state_next   = stsi_pkg::S_BS_CMP;
        end else if (req == stsi_pkg::REQ_INSERT) begin
          cmd.sh_init_up = 1'b1;
          state_next     = stsi_pkg::S_INS_SH;
        end else if (stat.lo_lt_cnt) begin
          cmd.chk_issue = 1'b1;
          state_next    = stsi_pkg::S_CHK_CMP;
        end else begin
          cmd.set_res    = 1'b1;
          cmd.res_status = stsi_pkg::ST_MISSING;
          state_next     = stsi_pkg::S_DONE;
        end
      end
      stsi_pkg::S_BS_CMP: begin
        cmd.bs_step = 1'b1;
        state_next  = stsi_pkg::S_BS_RD;
      end
      stsi_pkg::S_CHK_CMP: begin
        cmd.set_res    = 1'b1;
        cmd.res_found  = stat.eq;
        cmd.res_status = stat.eq ? stsi_pkg::ST_OK : stsi_pkg::ST_MISSING;
        state_next     = stsi_pkg::S_DONE;
      end
      stsi_pkg::S_INS_SH: begin
        if (!stat.ptr_gt_lo && !stat.pend) begin
          cmd.write_val = 1'b1;
          cmd.set_res   = 1'b1;
          state_next    = stsi_pkg::S_DONE;
        end else begin
          cmd.sh_up_step = 1'b1;
        end
      end
      stsi_pkg::S_RM_SCAN: begin
        if (stat.match) begin
          cmd.sh_init_dn = 1'b1;
          state_next     = stsi_pkg::S_RM_SH;
        end else if (!stat.ptr_lt_cnt && !stat.pend) begin
          cmd.set_res    = 1'b1;
          cmd.res_status = stsi_pkg::ST_MISSING;
          state_next     = stsi_pkg::S_DONE;
        end else begin
          cmd.scan_step = 1'b1;
        end
      end
      stsi_pkg::S_RM_SH: begin
        if (!stat.ptr_lt_cnt && !stat.pend) begin
          cmd.dec_cnt = 1'b1;
          cmd.set_res = 1'b1;
          state_next  = stsi_pkg::S_DONE;
        end else begin
          cmd.sh_dn_step = 1'b1;
        end
      end
      stsi_pkg::S_DONE: begin
        if (stat.out_free) begin
          cmd.push   = 1'b1;
          state_next = stsi_pkg::S_IDLE;
        end
      end
      default: state_next = stsi_pkg::S_IDLE;
    endcase
  end

endmodule

// File: rtl/core/sorted_table_insert_remove_search.sv
// Sorted table with insert, remove and binary search over a single-port-pair RAM.
// Top level; depends on stsi_pkg, stsi_ctrl, stsi_dp (which holds stsi_ram).
//
//   channel  dir  handshake            payload
//   s_*      in   s_tvalid/s_tready    tuser[1:0] req_type, tdata[31:0] value
//   m_*      out  m_tvalid/m_tready    tdata status, found_index, count_after
//   cfg_*    in   cfg_we               cfg_wdata descending_order
//
// One item at a time. Search: a binary search loop of one RAM read and one compare
// per step, then a check read of the found slot and the result. Insert: the search
// loop, then shifting one entry per cycle through the RAM, the write and the result.
// Remove: linear scan to the first match, then a shift to close the gap. A full
// table or an unused request code goes straight to the result.
// Reset clears the count, the order bit, the output valid and the sequencer state; the RAM is not cleared.
// A result waits in the output register; a stalled output holds the sequencer.
module sorted_table_insert_remove_search #(
  parameter int CAPACITY = 32
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic                                 cfg_wdata,  // descending_order
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  input  logic [stsi_pkg::ValueWidth-1:0]      s_tdata,    // [31:0] value
  input  logic [stsi_pkg::ReqWidth-1:0]        s_tuser,    // [1:0] req_type
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  output logic [stsi_pkg::OutWidth-1:0]        m_tdata     // [1:0] status, [6:2] found_index,
                                                           // [12:7] count_after
);

  stsi_pkg::cmd_t  cmd;
  stsi_pkg::stat_t stat;

  stsi_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tuser (s_tuser),
    .cmd     (cmd),
    .stat    (stat)
  );

  stsi_dp #(
    .CAPACITY(CAPACITY)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_value (s_tdata),
    .cmd      (cmd),
    .stat     (stat),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule

// File: tb/sorted_table_insert_remove_search_tb.sv
// Self-checking bench for sorted_table_insert_remove_search: insert, remove and search items
// are compared against an in-bench sorted-table predictor under random idling and stalls.
// Depends on stsi_pkg and the block's RTL only.
`timescale 1ns / 1ps

module sorted_table_insert_remove_search_tb;
  import stsi_pkg::*;

  localparam int Capacity = 32;
  localparam int HoldCycles = 400;
  localparam logic [ReqWidth-1:0] REQ_UNUSED = 2'd3;
  localparam logic ORDER_ASC  = 1'b0;
  localparam logic ORDER_DESC = 1'b1;

  typedef struct {
    logic [ReqWidth-1:0]   req;
    logic [ValueWidth-1:0] value;
  } request_t;

  typedef struct {
    logic [StatWidth-1:0]  status;
    logic [IdxWidth-1:0]   found_index;
    logic [CountWidth-1:0] count_after;
  } result_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_we = 1'b0;
  logic                  cfg_wdata = 1'b0;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [ValueWidth-1:0] s_tdata = '0;
  logic [ReqWidth-1:0]   s_tuser = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OutWidth-1:0]   m_tdata;

  request_t pending_requests[$];
  result_t  expected_results[$];

  logic signed [ValueWidth-1:0] table_vals [Capacity];
  int  table_count = 0;
  logic order_desc = ORDER_ASC;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_reqs = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int err_count = 0;

  logic [ValueWidth-1:0] value_pool [16];

  sorted_table_insert_remove_search #(.CAPACITY(Capacity)) dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic int lower_pos(input logic signed [ValueWidth-1:0] v);
    int lo;
    int hi;
    int mid;
    logic goes_first;
    lo = 0;
    hi = table_count;
    while (lo < hi) begin
      mid = (lo + hi) / 2;
      goes_first = order_desc ? (table_vals[mid] > v) : (table_vals[mid] < v);
      if (goes_first) lo = mid + 1;
      else hi = mid;
    end
    return lo;
  endfunction

  function automatic result_t predict_request(input logic [ReqWidth-1:0] req,
                                              input logic signed [ValueWidth-1:0] v);
    result_t r;
    int pos;
    int i;
    r.status = ST_OK;
    r.found_index = '0;
    case (req)
      REQ_INSERT: begin
        if (table_count >= Capacity) begin
          r.status = ST_FULL;
        end else begin
          pos = lower_pos(v);
          for (i = table_count; i > pos; i--) table_vals[i] = table_vals[i-1];
          table_vals[pos] = v;
          table_count++;
        end
      end
      REQ_REMOVE: begin
        pos = table_count;
        for (i = 0; i < table_count && pos == table_count; i++)
          if (table_vals[i] == v) pos = i;
        if (pos == table_count) begin
          r.status = ST_MISSING;
        end else begin
          for (i = pos; i + 1 < table_count; i++) table_vals[i] = table_vals[i+1];
          table_count--;
        end
      end
      REQ_SEARCH: begin
        pos = lower_pos(v);
        if (pos < table_count && table_vals[pos] == v) r.found_index = IdxWidth'(pos);
        else r.status = ST_MISSING;
      end
      default: ;
    endcase
    r.count_after = CountWidth'(table_count);
    return r;
  endfunction

  // sender
  always @(posedge clk) begin
    request_t nxt;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready)
        expected_results.push_back(predict_request(s_tuser, $signed(s_tdata)));
      if (!s_tvalid || s_tready) begin
        if (pending_requests.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          nxt = pending_requests.pop_front();
          s_tvalid <= 1'b1;
          s_tdata  <= nxt.value;
          s_tuser  <= nxt.req;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver ready, with long hold-off on request
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_seen != hold_reqs) begin
      hold_seen <= hold_reqs;
      hold_left <= HoldCycles;
      m_tready  <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      m_tready  <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // result checker
  always @(posedge clk) begin
    result_t want;
    logic [StatWidth-1:0]  got_status;
    logic [IdxWidth-1:0]   got_index;
    logic [CountWidth-1:0] got_count;
    if (!rst && m_tvalid && m_tready) begin
      got_status = m_tdata[1:0];
      got_index  = m_tdata[6:2];
      got_count  = m_tdata[12:7];
      if (expected_results.size() == 0) begin
        err_count++;
        if (err_count <= 10)
          $display("unexpected result: status %0d index %0d count %0d",
                   got_status, got_index, got_count);
      end else begin
        want = expected_results.pop_front();
        if (got_status !== want.status || got_index !== want.found_index ||
            got_count !== want.count_after) begin
          err_count++;
          if (err_count <= 10)
            $display("mismatch: status %0d/%0d index %0d/%0d count %0d/%0d (exp/act)",
                     want.status, got_status, want.found_index, got_index,
                     want.count_after, got_count);
        end
      end
    end
  end

  task automatic add_request(input logic [ReqWidth-1:0] req, input logic [ValueWidth-1:0] v);
    request_t item;
    item.req = req;
    item.value = v;
    pending_requests.push_back(item);
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (pending_requests.size() != 0 || s_tvalid || expected_results.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  task automatic set_order(input logic d);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= d;
    order_desc = d;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_traffic(input int idle_pct, input int stall_pct);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
  endtask

  function automatic logic [ValueWidth-1:0] pick_value();
    int r;
    r = $urandom_range(99);
    if (r < 60) return value_pool[$urandom_range(15)];
    if (r < 75) return ValueWidth'($signed($urandom_range(16)) - 8);
    return $urandom;
  endfunction

  task automatic add_random(input int n, input int ins_pct, input int rem_pct,
                            input int unused_pct);
    int i;
    int r;
    logic [ReqWidth-1:0] req;
    for (i = 0; i < n; i++) begin
      r = $urandom_range(99);
      if (r < ins_pct) req = REQ_INSERT;
      else if (r < ins_pct + rem_pct) req = REQ_REMOVE;
      else if (r < ins_pct + rem_pct + unused_pct) req = REQ_UNUSED;
      else req = REQ_SEARCH;
      add_request(req, pick_value());
    end
  endtask

  // empty the table so a new order starts from a well-formed state
  task automatic drain_table();
    logic [ValueWidth-1:0] snap[$];
    int i;
    for (i = 0; i < table_count; i++) snap.push_back(table_vals[i]);
    foreach (snap[k]) add_request(REQ_REMOVE, snap[k]);
    wait_drained();
  endtask

  initial begin
    int i;
    value_pool[0] = 32'h8000_0000;
    value_pool[1] = 32'h7fff_ffff;
    value_pool[2] = 32'h0000_0000;
    value_pool[3] = 32'hffff_ffff;
    value_pool[4] = 32'h0000_0001;
    for (i = 5; i < 16; i++) value_pool[i] = $urandom;

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    set_traffic(0, 0);
    set_order(ORDER_ASC);
    add_request(REQ_SEARCH, 32'd5);
    add_request(REQ_REMOVE, 32'd5);
    add_request(REQ_UNUSED, 32'd0);
    add_request(REQ_INSERT, 32'h0000_0000);
    add_request(REQ_INSERT, 32'h7fff_ffff);
    add_request(REQ_INSERT, 32'h8000_0000);
    add_request(REQ_INSERT, 32'hffff_ffff);
    add_request(REQ_INSERT, 32'h0000_0001);
    add_request(REQ_INSERT, 32'h0000_0000);
    add_request(REQ_SEARCH, 32'h0000_0000);
    add_request(REQ_SEARCH, 32'h7fff_ffff);
    add_request(REQ_SEARCH, 32'h8000_0000);
    add_request(REQ_SEARCH, 32'd5);
    add_request(REQ_REMOVE, 32'h0000_0000);
    add_request(REQ_REMOVE, 32'h0000_0000);
    add_request(REQ_REMOVE, 32'h0000_0000);
    add_request(REQ_SEARCH, 32'h0000_0000);
    add_request(REQ_UNUSED, 32'hffff_ffff);
    add_request(REQ_REMOVE, 32'h7fff_ffff);
    wait_drained();

    // order flipped with entries held: no re-sort
    set_order(ORDER_DESC);
    add_request(REQ_INSERT, 32'h0000_0000);
    add_request(REQ_SEARCH, 32'hffff_ffff);
    add_request(REQ_SEARCH, 32'h0000_0001);
    add_request(REQ_INSERT, 32'd7);
    add_request(REQ_REMOVE, 32'h8000_0000);
    add_request(REQ_SEARCH, 32'd7);
    wait_drained();
    drain_table();
    set_order(ORDER_ASC);

    set_traffic(0, 0);
    add_random(200, 40, 30, 5);
    wait_drained();

    set_traffic(76, 0);
    add_random(120, 70, 10, 3);
    wait_drained();

    set_traffic(0, 76);
    hold_reqs++;
    add_random(120, 40, 30, 5);
    wait_drained();

    drain_table();
    set_order(ORDER_DESC);
    set_traffic(35, 35);
    add_random(150, 70, 10, 3);
    wait_drained();

    set_traffic(0, 0);
    add_random(100, 15, 60, 3);
    wait_drained();

    set_order(ORDER_ASC);
    set_traffic(35, 35);
    add_random(130, 45, 30, 5);
    wait_drained();

    repeat (20) @(negedge clk);
    if (err_count == 0)
      $display("sorted_table_insert_remove_search_tb: done, clean");
    else
      $display("sorted_table_insert_remove_search_tb: done, errors");
    $finish;
  end

  initial begin
    #20000000;
    $display("sorted_table_insert_remove_search_tb: done, errors");
    $finish;
  end

endmodule
